[sv/efsd_pkg.sv]
// Shared types and constants for the earliest-free-server dispatch block.
// Used by efsd_servers and earliest_free_server_dispatch; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efsd_pkg;

    // Sizing
    localparam int MAX_SERVERS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SRV_IDX_W   = $clog2(MAX_SERVERS);

    // Field widths
    localparam int ACT_W   = 5;
    localparam int DUR_W   = 32;
    localparam int TIME_W  = 32;
    localparam int CLK_W   = 33;
    localparam int FREE_W  = 40;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 48;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 160;

    // Register word index (paddr[2])
    localparam logic REG_ACTIVE   = 1'b0;
    localparam logic REG_DURATION = 1'b1;

    // Reset values
    localparam logic [ACT_W-1:0] ACTIVE_RST   = 5'd1;
    localparam logic [DUR_W-1:0] DURATION_RST = 32'd65536000;
    localparam logic [DUR_W-1:0] MIN_DURATION = DUR_W'(1) << FRAC_BITS;

    // Control from the sequencer to the server file
    typedef struct packed {
        logic clear;      // start of run: all free times to zero
        logic scan_load;  // begin scan with server 0 as best
        logic scan_step;  // compare one more server
        logic wr_en;      // write done time to best server
    } srv_ctrl_t;

    // Status from the server file
    typedef struct packed {
        logic [SRV_IDX_W-1:0] best_idx;
        logic [FREE_W-1:0]    best_free;
        logic                 at_last;   // server under compare is the last active one
    } srv_stat_t;

endpackage

`default_nettype wire

[sv/efsd_servers.sv]
// Server free-time registers and the shared min-scan comparator.
// Depends on efsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efsd_servers (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  efsd_pkg::srv_ctrl_t                 ctrl,
    input  wire [efsd_pkg::SRV_IDX_W-1:0]       last_idx,
    input  wire [efsd_pkg::FREE_W-1:0]          wr_data,
    output efsd_pkg::srv_stat_t                 stat
);

    logic [efsd_pkg::FREE_W-1:0]    free_reg [efsd_pkg::MAX_SERVERS];
    logic [efsd_pkg::SRV_IDX_W-1:0] scan_idx_reg;
    logic [efsd_pkg::SRV_IDX_W-1:0] best_idx_reg;
    logic [efsd_pkg::FREE_W-1:0]    best_free_reg;
    logic [efsd_pkg::FREE_W-1:0]    cand_free;
    logic                           cand_less;

    // One compare per cycle against the running minimum; strict less keeps lowest index
    assign cand_free = free_reg[scan_idx_reg];
    assign cand_less = cand_free < best_free_reg;

    // Free-time file
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < efsd_pkg::MAX_SERVERS; i++) begin
                free_reg[i] <= '0;
            end
        end else if (ctrl.wr_en) begin
            free_reg[best_idx_reg] <= wr_data;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            best_idx_reg  <= '0;
            best_free_reg <= '0;
        end else if (ctrl.scan_load) begin
            scan_idx_reg  <= efsd_pkg::SRV_IDX_W'(1);
            best_idx_reg  <= '0;
            best_free_reg <= free_reg[0];
        end else if (ctrl.scan_step) begin
            scan_idx_reg <= scan_idx_reg + efsd_pkg::SRV_IDX_W'(1);
            if (cand_less) begin
                best_idx_reg  <= scan_idx_reg;
                best_free_reg <= cand_free;
            end
        end
    end

    assign stat.best_idx  = best_idx_reg;
    assign stat.best_free = best_free_reg;
    assign stat.at_last   = (scan_idx_reg == last_idx);

endmodule

`default_nettype wire

[sv/earliest_free_server_dispatch.sv]
// Top level of the earliest-free-server dispatch block: APB registers,
// sequencer, run totals and the result register. Depends on efsd_pkg, efsd_servers.
`timescale 1ns / 1ps
`default_nettype none

// One arrival word in, one result word out. An accepted arrival holds the
// input side until its result is loaded: the clock is advanced, a single
// comparator scans the free times of the active servers (1..16) one per
// cycle, then a wait step and an update step follow. An arrival that ends
// the run, or comes after it has ended, skips the scan and goes straight to
// the result step. A result waits in the output register while the next
// arrival is worked on; the block stalls in its last step only if that
// register is still full. Setting start_run in tuser clears clock, servers
// and totals before the arrival is handled. Write registers only while the
// block is idle.
module earliest_free_server_dispatch (
    input  wire                              aclk,
    input  wire                              aresetn,
    // APB configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [efsd_pkg::APB_AW-1:0]       paddr,
    input  wire [efsd_pkg::APB_DW-1:0]       pwdata,
    output logic [efsd_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    // Arrival stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [efsd_pkg::S_DATA_W-1:0]     s_tdata,  // inter_arrival[31:0], service_time[63:32]
    input  wire                              s_tuser,  // start_run
    // Result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [efsd_pkg::M_DATA_W-1:0]    m_tdata,  // assigned_server[3:0], wait_time[43:4],
                                                       // arrival_time[76:44], served_count[108:77],
                                                       // wait_total[156:109], zero[159:157]
    output logic                             m_tuser   // accepted
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_SCAN,
        ST_WAIT,
        ST_DONE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [efsd_pkg::ACT_W-1:0]     active_reg;
    logic [efsd_pkg::DUR_W-1:0]     duration_reg;
    logic [efsd_pkg::TIME_W-1:0]    ia_reg;
    logic [efsd_pkg::TIME_W-1:0]    svc_reg;
    logic [efsd_pkg::CLK_W-1:0]     clock_reg;
    logic                           run_over_reg;
    logic [efsd_pkg::CNT_W-1:0]     count_reg;
    logic [efsd_pkg::SUM_W-1:0]     sum_reg;
    logic                           acc_reg;
    logic [efsd_pkg::FREE_W-1:0]    wait_reg;
    logic [efsd_pkg::FREE_W-1:0]    start_reg;
    logic                           m_valid_reg;
    logic [efsd_pkg::M_DATA_W-1:0]  m_data_reg;
    logic                           m_user_reg;

    efsd_pkg::srv_ctrl_t            srv_ctrl;
    efsd_pkg::srv_stat_t            srv_stat;
    logic [efsd_pkg::SRV_IDX_W-1:0] last_idx;
    logic [efsd_pkg::DUR_W-1:0]     limit;
    logic [efsd_pkg::CLK_W-1:0]     clock_sum;
    logic [efsd_pkg::FREE_W-1:0]    clock_ext;
    logic [efsd_pkg::FREE_W:0]      done_sum;
    logic [efsd_pkg::FREE_W-1:0]    done_sat;
    logic [efsd_pkg::SUM_W:0]       wsum_sum;
    logic                           in_acc;
    logic                           cfg_wr;
    logic                           out_free;
    logic [efsd_pkg::SRV_IDX_W-1:0] res_idx;
    logic [efsd_pkg::FREE_W-1:0]    res_wait;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= efsd_pkg::ACTIVE_RST;
            duration_reg <= efsd_pkg::DURATION_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                efsd_pkg::REG_ACTIVE:   active_reg   <= pwdata[efsd_pkg::ACT_W-1:0];
                efsd_pkg::REG_DURATION: duration_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            efsd_pkg::REG_ACTIVE:   prdata = {{(efsd_pkg::APB_DW-efsd_pkg::ACT_W){1'b0}},
                                              active_reg};
            efsd_pkg::REG_DURATION: prdata = duration_reg;
            default:                prdata = '0;
        endcase
    end

    // Clamp server count and run length
    always_comb begin
        if (active_reg == '0) begin
            last_idx = '0;
        end else if (active_reg > efsd_pkg::ACT_W'(efsd_pkg::MAX_SERVERS)) begin
            last_idx = efsd_pkg::SRV_IDX_W'(efsd_pkg::MAX_SERVERS - 1);
        end else begin
            last_idx = efsd_pkg::SRV_IDX_W'(active_reg - efsd_pkg::ACT_W'(1));
        end
    end

    assign limit = (duration_reg < efsd_pkg::MIN_DURATION) ? efsd_pkg::MIN_DURATION
                                                           : duration_reg;

    // Datapath
    assign clock_sum = clock_reg + {1'b0, ia_reg};
    assign clock_ext = {{(efsd_pkg::FREE_W-efsd_pkg::CLK_W){1'b0}}, clock_reg};
    assign done_sum  = {1'b0, start_reg}
                     + {{(efsd_pkg::FREE_W+1-efsd_pkg::TIME_W){1'b0}}, svc_reg};
    assign done_sat  = done_sum[efsd_pkg::FREE_W] ? '1 : done_sum[efsd_pkg::FREE_W-1:0];
    assign wsum_sum  = {1'b0, sum_reg}
                     + {{(efsd_pkg::SUM_W+1-efsd_pkg::FREE_W){1'b0}}, wait_reg};

    // Handshakes
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Server file control
    always_comb begin
        srv_ctrl.clear     = in_acc && s_tuser;
        srv_ctrl.scan_load = (state_reg == ST_ADV);
        srv_ctrl.scan_step = (state_reg == ST_SCAN);
        srv_ctrl.wr_en     = (state_reg == ST_DONE);
    end

    efsd_servers u_servers (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (srv_ctrl),
        .last_idx (last_idx),
        .wr_data  (done_sat),
        .stat     (srv_stat)
    );

    // Rejected results carry zero server and wait
    assign res_idx  = acc_reg ? srv_stat.best_idx : '0;
    assign res_wait = acc_reg ? wait_reg : '0;

    // Sequencer, run totals and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clock_reg    <= '0;
            run_over_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            acc_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drained word; a word loaded in the last step takes its place
            if (m_valid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        ia_reg  <= s_tdata[efsd_pkg::TIME_W-1:0];
                        svc_reg <= s_tdata[2*efsd_pkg::TIME_W-1:efsd_pkg::TIME_W];
                        if (s_tuser) begin
                            clock_reg    <= '0;
                            run_over_reg <= 1'b0;
                            count_reg    <= '0;
                            sum_reg      <= '0;
                        end
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    // advance clock unless frozen; end of run rejects
                    if (run_over_reg) begin
                        acc_reg   <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else begin
                        clock_reg <= clock_sum;
                        if (clock_sum >= {1'b0, limit}) begin
                            run_over_reg <= 1'b1;
                            acc_reg      <= 1'b0;
                            state_reg    <= ST_FINISH;
                        end else begin
                            state_reg <= (last_idx == '0) ? ST_WAIT : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (srv_stat.at_last) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    // wait = max(0, free - now), start = max(free, now)
                    if (srv_stat.best_free > clock_ext) begin
                        wait_reg  <= srv_stat.best_free - clock_ext;
                        start_reg <= srv_stat.best_free;
                    end else begin
                        wait_reg  <= '0;
                        start_reg <= clock_ext;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (count_reg != '1) begin
                        count_reg <= count_reg + efsd_pkg::CNT_W'(1);
                    end
                    sum_reg   <= wsum_sum[efsd_pkg::SUM_W] ? '1
                                                           : wsum_sum[efsd_pkg::SUM_W-1:0];
                    acc_reg   <= 1'b1;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= acc_reg;
                        m_data_reg  <= {{(efsd_pkg::M_DATA_W - efsd_pkg::SRV_IDX_W
                                          - efsd_pkg::FREE_W - efsd_pkg::CLK_W
                                          - efsd_pkg::CNT_W - efsd_pkg::SUM_W){1'b0}},
                                        sum_reg, count_reg, clock_reg, res_wait, res_idx};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // start_run clears the clock and the end-of-run flag before the arrival is handled
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (clock_reg == '0 && !run_over_reg))
        else $error("start_run did not clear run state");

    // a rejected word reports no server and no wait
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[43:0] == '0))
        else $error("rejected word carries server or wait");

    // the chosen server is always within the active range
    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> (srv_stat.best_idx <= last_idx))
        else $error("chosen server outside active range");

    // a new word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire
